>>> rtl/core/bpsa_pkg.sv
// Shared types, widths and status codes of the block pool slot allocator.
// Depends on nothing; used by every module under rtl/core.
`timescale 1ns / 1ps

package bpsa_pkg;

  localparam int MAP_DEPTH        = 1024;
  localparam int WORD_W           = 32;
  localparam int MAP_WORDS        = MAP_DEPTH / WORD_W;
  localparam int WORD_AW          = $clog2(MAP_WORDS);
  localparam int BIT_W            = $clog2(WORD_W);
  localparam int SLOT_W           = $clog2(MAP_DEPTH);
  localparam int CNT_W            = SLOT_W + 1;
  localparam int BLKC_W           = 9;
  localparam int OPEN_W           = 7;
  localparam int STATUS_W         = 2;

  localparam int DEF_BLOCK_SLOTS  = 16;
  localparam int DEF_MAX_BLOCKS   = 64;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE     = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
    logic [WORD_W-1:0]  data;
  } map_wr_t;

  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
  } map_rd_t;

endpackage

>>> rtl/core/bpsa_ffs.sv
// Shared find-first-set unit: lowest set bit of one map word or summary word.
// Depends on bpsa_pkg.
`timescale 1ns / 1ps

module bpsa_ffs (
  input  logic [bpsa_pkg::WORD_W-1:0] vec,
  output logic                        found,
  output logic [bpsa_pkg::BIT_W-1:0]  idx
);

  always_comb begin
    found = |vec;
    idx   = '0;
    for (int i = bpsa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = bpsa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

>>> rtl/core/bpsa_map.sv
// Free-slot bitmap: word memory with one summary bit per word.
// A clear summary bit marks the word empty, whatever the memory holds.
// Depends on bpsa_pkg.
`timescale 1ns / 1ps

module bpsa_map (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bpsa_pkg::map_wr_t              wr,
  input  bpsa_pkg::map_rd_t              rd,
  output logic [bpsa_pkg::WORD_W-1:0]    rd_data,
  output logic [bpsa_pkg::MAP_WORDS-1:0] summary
);

  logic [bpsa_pkg::WORD_W-1:0]    mem [bpsa_pkg::MAP_WORDS];
  logic [bpsa_pkg::WORD_W-1:0]    rd_q_r;
  logic                           rd_vld_r;
  logic [bpsa_pkg::MAP_WORDS-1:0] summ_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_q_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summ_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        summ_r[wr.addr] <= |wr.data;
      end
      if (rd.en) begin
        rd_vld_r <= summ_r[rd.addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;
  assign summary = summ_r;

endmodule

>>> rtl/core/block_pool_slot_allocator_core.sv
// Block pool slot allocator top level: request sequencer, counters, result register.
// Depends on bpsa_pkg, bpsa_ffs and bpsa_map.
//
//   channel | direction | tdata                                    | tuser
//   in_     | slave     | [9:0] slot_in                            | [0] kind
//   out_    | master    | [1:0] status [11:2] slot_out             | -
//           |           | [22:12] used_slots [29:23] open_blocks   |
//
// Allocate and free pass through accept, summary search or range check with the word
// read, word search and write back, and result load; an exhausted allocate or an
// outside free skips the word search.
// A block-opening allocate sweeps one map word per cycle over the map words the block spans.
// Reset clears the summary bits, so the map needs no clearing pass.
// in_tready is high only while idle; a stalled output holds one result and the next request.
`timescale 1ns / 1ps

module block_pool_slot_allocator_core #(
  parameter int BLOCK_SLOTS = bpsa_pkg::DEF_BLOCK_SLOTS,
  parameter int MAX_BLOCKS  = bpsa_pkg::DEF_MAX_BLOCKS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] slot_in
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [11:2] slot_out, [22:12] used_slots,
                                  // [29:23] open_blocks
);

  localparam int SW = bpsa_pkg::SLOT_W;
  localparam int CW = bpsa_pkg::CNT_W;
  localparam int BW = bpsa_pkg::BLKC_W;
  localparam int WW = bpsa_pkg::WORD_W;
  localparam int AW = bpsa_pkg::WORD_AW;
  localparam int XW = CW + 1;

  localparam logic [XW-1:0] BS_X    = XW'(BLOCK_SLOTS);
  localparam logic [XW-1:0] DEPTH_X = XW'(bpsa_pkg::MAP_DEPTH);
  localparam logic [BW-1:0] MAXB    = BW'(MAX_BLOCKS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_WORD = 3'd2;
  localparam logic [2:0] S_OPEN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic                         kind_r, kind_nxt;
  logic [SW-1:0]                slot_r, slot_nxt;
  logic [AW-1:0]                word_r, word_nxt;
  logic [bpsa_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [SW-1:0]                grant_r, grant_nxt;
  logic [CW-1:0]                alloc_cnt_r, alloc_cnt_nxt;
  logic [BW-1:0]                blk_cnt_r, blk_cnt_nxt;
  logic [CW-1:0]                open_slots_r, open_slots_nxt;
  logic [SW-1:0]                lo_r, lo_nxt;
  logic [SW-1:0]                hi_r, hi_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [31:0]                  out_tdata_r, out_tdata_nxt;

  bpsa_pkg::map_wr_t            map_wr;
  bpsa_pkg::map_rd_t            map_rd;
  logic [WW-1:0]                map_rdata;
  logic [bpsa_pkg::MAP_WORDS-1:0] map_summary;

  logic [WW-1:0]                ffs_vec;
  logic                         ffs_found;
  logic [bpsa_pkg::BIT_W-1:0]   ffs_idx;

  logic [XW-1:0]                next_end;
  logic                         can_open;
  logic [WW-1:0]                lo_mask, hi_mask;
  logic [WW-1:0]                bit_sel;
  logic                         load_out;

  bpsa_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (map_wr),
    .rd      (map_rd),
    .rd_data (map_rdata),
    .summary (map_summary)
  );

  bpsa_ffs u_ffs (
    .vec   (ffs_vec),
    .found (ffs_found),
    .idx   (ffs_idx)
  );

  assign next_end = {1'b0, open_slots_r} + BS_X;
  assign can_open = (blk_cnt_r < MAXB) && (next_end <= DEPTH_X);
  assign bit_sel  = WW'(1) << slot_r[bpsa_pkg::BIT_W-1:0];

  always_comb begin
    if (word_r > lo_r[SW-1 -: AW]) begin
      lo_mask = '1;
    end else if (word_r == lo_r[SW-1 -: AW]) begin
      lo_mask = '1 << lo_r[bpsa_pkg::BIT_W-1:0];
    end else begin
      lo_mask = '0;
    end
    if (word_r < hi_r[SW-1 -: AW]) begin
      hi_mask = '1;
    end else if (word_r == hi_r[SW-1 -: AW]) begin
      hi_mask = '1 >> (~hi_r[bpsa_pkg::BIT_W-1:0]);
    end else begin
      hi_mask = '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    slot_nxt       = slot_r;
    word_nxt       = word_r;
    status_nxt     = status_r;
    grant_nxt      = grant_r;
    alloc_cnt_nxt  = alloc_cnt_r;
    blk_cnt_nxt    = blk_cnt_r;
    open_slots_nxt = open_slots_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r;
    map_wr         = '0;
    map_rd         = '0;
    ffs_vec        = map_summary;
    load_out       = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser[0];
          slot_nxt  = in_tdata[SW-1:0];
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        grant_nxt  = '0;
        status_nxt = bpsa_pkg::ST_OK;
        if (kind_r == bpsa_pkg::KIND_ALLOC) begin
          ffs_vec = map_summary;
          if (ffs_found) begin
            map_rd.en   = 1'b1;
            map_rd.addr = AW'(ffs_idx);
            word_nxt    = AW'(ffs_idx);
            state_nxt   = S_WORD;
          end else if (can_open) begin
            lo_nxt    = SW'(open_slots_r + CW'(1));
            hi_nxt    = SW'(next_end - XW'(1));
            word_nxt  = open_slots_r[SW-1 -: AW];
            state_nxt = S_OPEN;
          end else begin
            status_nxt = bpsa_pkg::ST_EXHAUSTED;
            state_nxt  = S_DONE;
          end
        end else begin
          if ({1'b0, slot_r} >= open_slots_r) begin
            status_nxt = bpsa_pkg::ST_OUTSIDE;
            state_nxt  = S_DONE;
          end else begin
            map_rd.en   = 1'b1;
            map_rd.addr = slot_r[SW-1 -: AW];
            word_nxt    = slot_r[SW-1 -: AW];
            state_nxt   = S_WORD;
          end
        end
      end
      S_WORD: begin
        ffs_vec   = map_rdata;
        state_nxt = S_DONE;
        if (kind_r == bpsa_pkg::KIND_ALLOC) begin
          map_wr.en     = 1'b1;
          map_wr.addr   = word_r;
          map_wr.data   = map_rdata & ~(WW'(1) << ffs_idx);
          grant_nxt     = {word_r, ffs_idx};
          alloc_cnt_nxt = alloc_cnt_r + CW'(1);
        end else if ((map_rdata & bit_sel) != '0) begin
          status_nxt = bpsa_pkg::ST_DOUBLE_FREE;
        end else begin
          map_wr.en   = 1'b1;
          map_wr.addr = word_r;
          map_wr.data = map_rdata | bit_sel;
          if (alloc_cnt_r != '0) begin
            alloc_cnt_nxt = alloc_cnt_r - CW'(1);
          end
        end
      end
      S_OPEN: begin
        map_wr.en   = 1'b1;
        map_wr.addr = word_r;
        map_wr.data = lo_mask & hi_mask;
        if (word_r == hi_r[SW-1 -: AW]) begin
          grant_nxt      = open_slots_r[SW-1:0];
          blk_cnt_nxt    = blk_cnt_r + BW'(1);
          open_slots_nxt = CW'(next_end);
          alloc_cnt_nxt  = alloc_cnt_r + CW'(1);
          state_nxt      = S_DONE;
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          load_out       = 1'b1;
          out_tdata_nxt  = {2'b00, blk_cnt_r[bpsa_pkg::OPEN_W-1:0], alloc_cnt_r,
                            grant_r, status_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      alloc_cnt_r  <= '0;
      blk_cnt_r    <= '0;
      open_slots_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      alloc_cnt_r  <= alloc_cnt_nxt;
      blk_cnt_r    <= blk_cnt_nxt;
      open_slots_r <= open_slots_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    slot_r      <= slot_nxt;
    word_r      <= word_nxt;
    status_r    <= status_nxt;
    grant_r     <= grant_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_alloc_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_cnt_r <= open_slots_r)
    else $error("allocated count passes the open slots");

  a_blocks_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    blk_cnt_r <= MAXB && {1'b0, open_slots_r} <= DEPTH_X)
    else $error("open blocks pass the limit");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_CMD)
    else $error("accepted request did not start");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_tvalid_r && state_r == S_IDLE)
    else $error("finished result not presented");

  a_open_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OPEN && word_r == hi_r[SW-1 -: AW] |=> blk_cnt_r == $past(blk_cnt_r) + BW'(1))
    else $error("block sweep ended without opening a block");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for block_pool_slot_allocator_core: directed table, then random
// allocate/free traffic with random gaps and stalls, checked against a local pool model.
// Depends on bpsa_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int POOL_BLOCK = bpsa_pkg::DEF_BLOCK_SLOTS;
  localparam int POOL_MAXB  = bpsa_pkg::DEF_MAX_BLOCKS;
  localparam int MAP_DEPTH  = bpsa_pkg::MAP_DEPTH;
  localparam int STATUS_W   = bpsa_pkg::STATUS_W;
  localparam int SLOT_W     = bpsa_pkg::SLOT_W;
  localparam int CNT_W      = bpsa_pkg::CNT_W;
  localparam int OPEN_W     = bpsa_pkg::OPEN_W;

  localparam logic [STATUS_W-1:0] ST_OK          = bpsa_pkg::ST_OK;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = bpsa_pkg::ST_DOUBLE_FREE;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = bpsa_pkg::ST_EXHAUSTED;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE     = bpsa_pkg::ST_OUTSIDE;

  localparam logic KIND_ALLOC = bpsa_pkg::KIND_ALLOC;
  localparam logic KIND_FREE  = bpsa_pkg::KIND_FREE;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    used;
    logic [OPEN_W-1:0]   blocks;
  } reply_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [4:0]        reps;
    logic              typed;
    reply_t            want;
  } row_t;

  localparam int NUM_ROWS = 12;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{KIND_FREE,  10'd1023, 5'd1,  1'b1, '{ST_OUTSIDE,     10'd0,  11'd0,  7'd0}},
    '{KIND_ALLOC, 10'd1023, 5'd1,  1'b1, '{ST_OK,          10'd0,  11'd1,  7'd1}},
    '{KIND_ALLOC, 10'd0,    5'd1,  1'b1, '{ST_OK,          10'd1,  11'd2,  7'd1}},
    '{KIND_FREE,  10'd1,    5'd1,  1'b0, '0},
    '{KIND_FREE,  10'd1,    5'd1,  1'b1, '{ST_DOUBLE_FREE, 10'd0,  11'd1,  7'd1}},
    '{KIND_FREE,  10'd16,   5'd1,  1'b1, '{ST_OUTSIDE,     10'd0,  11'd1,  7'd1}},
    '{KIND_ALLOC, 10'd682,  5'd15, 1'b0, '0},
    '{KIND_ALLOC, 10'd341,  5'd1,  1'b1, '{ST_OK,          10'd16, 11'd17, 7'd2}},
    '{KIND_FREE,  10'd0,    5'd1,  1'b0, '0},
    '{KIND_FREE,  10'd31,   5'd1,  1'b1, '{ST_DOUBLE_FREE, 10'd0,  11'd16, 7'd2}},
    '{KIND_FREE,  10'd32,   5'd1,  1'b1, '{ST_OUTSIDE,     10'd0,  11'd16, 7'd2}},
    '{KIND_ALLOC, 10'd0,    5'd1,  1'b1, '{ST_OK,          10'd0,  11'd17, 7'd2}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [9:0] slot_in
  logic [0:0]  in_tuser;   // [0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [1:0] status, [11:2] slot_out, [22:12] used_slots,
                           // [29:23] open_blocks

  bit          vacant [MAP_DEPTH];
  int unsigned blocks_open = 0;
  int unsigned slots_used  = 0;
  reply_t      awaited [$];
  int unsigned mismatches  = 0;
  bit          pace_on     = 1'b1;
  bit          stall_on    = 1'b1;

  block_pool_slot_allocator_core #(
    .BLOCK_SLOTS (POOL_BLOCK),
    .MAX_BLOCKS  (POOL_MAXB)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(4_000_000);
    $display("testbench: errors");
    $finish;
  end

  task automatic report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Grant, release or reject one request and return the reply it yields.
  function automatic reply_t serve_request(logic kind, logic [SLOT_W-1:0] slot);
    reply_t      r;
    int unsigned span;
    int unsigned i;
    bit          hit;
    r    = '0;
    hit  = 1'b0;
    span = blocks_open * POOL_BLOCK;
    if (span > MAP_DEPTH) span = MAP_DEPTH;
    if (kind == KIND_ALLOC) begin
      for (i = 0; i < span && !hit; i++) begin
        if (vacant[i]) begin
          hit    = 1'b1;
          r.slot = SLOT_W'(i);
        end
      end
      if (hit) begin
        vacant[r.slot] = 1'b0;
        slots_used++;
      end else if (blocks_open < POOL_MAXB && (blocks_open + 1) * POOL_BLOCK <= MAP_DEPTH) begin
        for (i = 1; i < POOL_BLOCK; i++) vacant[(span + i) % MAP_DEPTH] = 1'b1;
        r.slot = SLOT_W'(span);
        blocks_open++;
        slots_used++;
      end else begin
        r.status = ST_EXHAUSTED;
      end
    end else begin
      if (slot >= span) begin
        r.status = ST_OUTSIDE;
      end else if (vacant[slot]) begin
        r.status = ST_DOUBLE_FREE;
      end else begin
        vacant[slot] = 1'b1;
        if (slots_used > 0) slots_used--;
      end
    end
    r.used   = CNT_W'(slots_used);
    r.blocks = OPEN_W'(blocks_open);
    return r;
  endfunction

  // Mostly a granted slot, else an in-range, outside or arbitrary index.
  function automatic logic [SLOT_W-1:0] pick_release_slot();
    int unsigned span;
    int unsigned start;
    int unsigned k;
    int unsigned r;
    span = blocks_open * POOL_BLOCK;
    if (span > MAP_DEPTH) span = MAP_DEPTH;
    r = $urandom_range(0, 99);
    if (span == 0) return SLOT_W'($urandom_range(0, MAP_DEPTH - 1));
    if (r < 60) begin
      start = $urandom_range(0, span - 1);
      for (k = 0; k < span; k++) begin
        if (!vacant[(start + k) % span]) return SLOT_W'((start + k) % span);
      end
    end
    if (r < 80) return SLOT_W'($urandom_range(0, span - 1));
    if (r < 90 && span < MAP_DEPTH) return SLOT_W'($urandom_range(span, MAP_DEPTH - 1));
    return SLOT_W'($urandom_range(0, MAP_DEPTH - 1));
  endfunction

  task automatic pause_sender();
    int unsigned r;
    if (!pace_on) return;
    r = $urandom_range(0, 99);
    if (r < 45) return;
    in_tvalid <= 1'b0;
    if (r < 85)      repeat ($urandom_range(1, 3))   @(negedge clk);
    else if (r < 97) repeat ($urandom_range(4, 12))  @(negedge clk);
    else             repeat ($urandom_range(20, 60)) @(negedge clk);
  endtask

  // Present one request, hold it until accepted, then advance to the next falling edge.
  task automatic send_request(logic kind, logic [SLOT_W-1:0] slot, bit typed, reply_t want);
    reply_t got;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(16 - SLOT_W){1'b0}}, slot};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    got = serve_request(kind, slot);
    awaited.insert(awaited.size(), typed ? want : got);
    @(negedge clk);
  endtask

  task automatic random_request(int unsigned alloc_pct);
    logic              kind;
    logic [SLOT_W-1:0] slot;
    kind = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
    slot = (kind == KIND_ALLOC) ? SLOT_W'($urandom_range(0, MAP_DEPTH - 1))
                                : pick_release_slot();
    pause_sender();
    send_request(kind, slot, 1'b0, '0);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (awaited.size() != 0);
  endtask

  initial begin
    int unsigned n;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!stall_on) begin
        out_tready <= 1'b1;
        @(negedge clk);
      end else begin
        n = $urandom_range(0, 99);
        if (n < 50) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 16)) @(negedge clk);
        end else begin
          out_tready <= 1'b0;
          if (n < 85)      repeat ($urandom_range(1, 3))   @(negedge clk);
          else if (n < 97) repeat ($urandom_range(4, 15))  @(negedge clk);
          else             repeat ($urandom_range(25, 70)) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_reply
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited.size() == 0) begin
        report("reply beat with nothing awaited");
      end else begin
        want = awaited.pop_front();
        if (out_tdata[1:0] !== want.status)
          report($sformatf("status got %0d want %0d", out_tdata[1:0], want.status));
        if (out_tdata[11:2] !== want.slot)
          report($sformatf("slot_out got %0d want %0d", out_tdata[11:2], want.slot));
        if (out_tdata[22:12] !== want.used)
          report($sformatf("used_slots got %0d want %0d", out_tdata[22:12], want.used));
        if (out_tdata[29:23] !== want.blocks)
          report($sformatf("open_blocks got %0d want %0d", out_tdata[29:23], want.blocks));
        if (out_tdata[31:30] !== 2'b00)
          report($sformatf("padding bits got %b", out_tdata[31:30]));
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned n;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_ROWS; i++) begin
      for (n = 0; n < DIRECTED_ROWS[i].reps; n++) begin
        pause_sender();
        send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].slot,
                     DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
    end
    hold_until_drained();

    repeat (200) random_request(60);
    hold_until_drained();

    // fill the pool to the block limit, first half back to back
    pace_on  = 1'b0;
    stall_on = 1'b0;
    while (slots_used < MAP_DEPTH / 2) random_request(95);
    pace_on  = 1'b1;
    stall_on = 1'b1;
    while (slots_used < MAP_DEPTH) random_request(95);
    repeat (12) random_request(100);
    repeat (20) random_request(50);
    hold_until_drained();

    repeat (100) random_request(30);
    repeat (100) random_request(55);
    hold_until_drained();
    repeat (16) @(negedge clk);

    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
